// ===== src/dbs_pkg.sv =====
package dbs_pkg;

   localparam int BUCKET_COUNT      = 4096;
   localparam int MAX_POLYGONS      = 1024;
   localparam int MAX_VERTICES      = 4096;
   localparam int MAX_POLY_VERTICES = 255;
   localparam int DIV_STEPS         = 35;

   typedef enum logic [1:0] {
      OP_CLEAR  = 2'd0,
      OP_VERTEX = 2'd1,
      OP_DRAIN  = 2'd2
   } op_type;

   typedef enum logic [2:0] {
      ST_ACCEPTED   = 3'd0,
      ST_TOO_FEW    = 3'd1,
      ST_BEHIND     = 3'd2,
      ST_FULL       = 3'd3,
      ST_DRAINED    = 3'd4,
      ST_DRAIN_DONE = 3'd5
   } status_type;

   typedef enum logic [2:0] {
      CSR_NORMAL_X      = 3'd0,
      CSR_NORMAL_Y      = 3'd1,
      CSR_NORMAL_Z      = 3'd2,
      CSR_VIEW_DISTANCE = 3'd3,
      CSR_NEAR_LIMIT    = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [1:0]         operation;
      logic signed [23:0] pos_x;
      logic signed [23:0] pos_y;
      logic signed [23:0] pos_z;
      logic               last_vertex;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [9:0]  polygon_index;
      logic [11:0] first_vertex;
      logic [7:0]  vertex_total;
      logic [11:0] bucket;
   } rsp_type;

endpackage

// ===== src/depth_bucket_sort_polys.sv =====
// Channel   Ports                               Direction  Beat
// request   req_valid, req_stall, req_payload   in         one operation (clear/vertex/drain)
// response  rsp_valid, rsp_stall, rsp_payload   out        one status record
// csr       csr_write_en, csr_index, csr_wdata  in         one register write
//
// Vertex: three products on the shared 24x16 multiplier, accumulate, fold, then the next
// request is accepted. Last vertex of a kept polygon: then a divide (one quotient bit per
// cycle) and the bucket and link steps. Drain: each polygon of a bucket in turn, buckets
// scanned from the top bucket down past empty ones, then a drain done beat.
// Reset and clear each start a sweep of the bucket head memory; no beat is taken.
// A finished beat waits in the output register, and the next request is taken meanwhile.
module depth_bucket_sort_polys
   import dbs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_payload,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_payload,
   input  logic        csr_write_en,
   input  logic [2:0]  csr_index,
   input  logic [25:0] csr_wdata
);

   typedef enum logic [11:0] {
      S_CLR   = 12'b000000000001,
      S_IDLE  = 12'b000000000010,
      S_VMUL  = 12'b000000000100,
      S_VACC  = 12'b000000001000,
      S_VFIN  = 12'b000000010000,
      S_DIV   = 12'b000000100000,
      S_BKT   = 12'b000001000000,
      S_LINK  = 12'b000010000000,
      S_LINK2 = 12'b000100000000,
      S_DRAIN = 12'b001000000000,
      S_DHEAD = 12'b010000000000,
      S_DOUT  = 12'b100000000000
   } state_type;

   state_type state_ff;

   logic signed [15:0] normal_x_ff, normal_y_ff, normal_z_ff;
   logic signed [25:0] view_distance_ff;
   logic [19:0]        near_limit_ff;

   req_type            item_ff;
   logic [1:0]         k_ff;
   logic signed [39:0] product_ff;
   logic signed [41:0] acc_ff;

   logic [10:0]        pcnt_ff;
   logic [12:0]        vcnt_ff;
   logic [12:0]        open_first_ff;
   logic [8:0]         open_total_ff;
   logic signed [35:0] sum_ff;
   logic signed [27:0] peak_ff;

   logic [34:0]        div_q_ff;
   logic [8:0]         div_rem_ff;
   logic [5:0]         div_cnt_ff;
   logic               neg_ff;
   logic [11:0]        bk_ff;

   logic [11:0]        drain_bucket_ff;
   logic [10:0]        drain_item_ff;
   logic               drain_done_ff;
   logic [11:0]        clr_addr_ff;

   logic               rsp_valid_ff;
   rsp_type            rsp_ff;

   logic [10:0]        heads_mem [BUCKET_COUNT];
   logic [10:0]        links_mem [MAX_POLYGONS];
   logic [20:0]        rec_mem   [MAX_POLYGONS];
   logic [10:0]        head_q_ff;
   logic [10:0]        link_q_ff;
   logic [20:0]        rec_q_ff;

   // output register control
   logic    out_free;
   logic    emit;
   rsp_type emit_data;

   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign req_stall   = (state_ff != S_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // shared multiplier operand select
   logic signed [23:0] mul_a;
   logic signed [15:0] mul_b;

   always_comb begin
      unique case (k_ff)
         2'd0: begin
            mul_a = item_ff.pos_x;
            mul_b = normal_x_ff;
         end
         2'd1: begin
            mul_a = item_ff.pos_y;
            mul_b = normal_y_ff;
         end
         default: begin
            mul_a = item_ff.pos_z;
            mul_b = normal_z_ff;
         end
      endcase
   end

   // polygon update and verdict on the final vertex
   logic               room;
   logic signed [27:0] depth;
   logic [12:0]        first_w;
   logic signed [35:0] sum_n;
   logic signed [27:0] peak_n;
   logic [8:0]         total_n;
   logic [12:0]        vcnt_n;
   logic               full;
   logic signed [29:0] peak_ahead;
   status_type         verdict;

   always_comb begin
      room    = (open_total_ff <= 9'(MAX_POLY_VERTICES));
      depth   = acc_ff[41:14];
      first_w = (open_total_ff == 9'd0) ? vcnt_ff : open_first_ff;
      sum_n   = room ? (sum_ff + 36'(depth)) : sum_ff;
      peak_n  = (room && (depth > peak_ff)) ? depth : peak_ff;
      total_n = room ? (open_total_ff + 9'd1) : open_total_ff;
      vcnt_n  = room ? (vcnt_ff + 13'd1) : vcnt_ff;
      full    = (pcnt_ff >= 11'(MAX_POLYGONS)) || (total_n > 9'(MAX_POLY_VERTICES)) ||
                (({1'b0, first_w} + {5'b0, total_n}) > 14'(MAX_VERTICES));
      peak_ahead = 30'(peak_n) - 30'(view_distance_ff);
      priority if (full)
         verdict = ST_FULL;
      else if (total_n < 9'd3)
         verdict = ST_TOO_FEW;
      else if (peak_ahead < $signed({10'b0, near_limit_ff}))
         verdict = ST_BEHIND;
      else
         verdict = ST_ACCEPTED;
   end

   // one restoring divide step
   logic [9:0] rem_sh;
   logic       q_bit;
   logic [9:0] rem_n;

   always_comb begin
      rem_sh = {div_rem_ff, div_q_ff[34]};
      q_bit  = (rem_sh >= {1'b0, open_total_ff});
      rem_n  = q_bit ? (rem_sh - {1'b0, open_total_ff}) : rem_sh;
   end

   // bucket from floored mean depth
   logic [35:0]        mean_w;
   logic signed [29:0] ahead;
   logic signed [29:0] bsh;
   logic [11:0]        bk_n;

   always_comb begin
      mean_w = neg_ff ? ~{1'b0, div_q_ff} : {1'b0, div_q_ff};
      ahead  = $signed(mean_w[29:0]) - 30'(view_distance_ff);
      bsh    = ahead >>> 8;
      priority if (ahead[29])
         bk_n = 12'd0;
      else if (|bsh[29:12])
         bk_n = 12'(BUCKET_COUNT - 1);
      else
         bk_n = bsh[11:0];
   end

   // memory ports
   logic        head_we;
   logic [11:0] head_waddr;
   logic [10:0] head_wdata;
   logic [11:0] head_raddr;
   logic        link_we;
   logic [9:0]  link_raddr;

   always_comb begin
      head_we    = 1'b0;
      head_waddr = clr_addr_ff;
      head_wdata = 11'd0;
      if (state_ff == S_CLR) begin
         head_we = 1'b1;
      end else if (state_ff == S_LINK2 && out_free) begin
         head_we    = 1'b1;
         head_waddr = bk_ff;
         head_wdata = pcnt_ff + 11'd1;
      end
      head_raddr = (state_ff == S_LINK || state_ff == S_LINK2) ? bk_ff : drain_bucket_ff;
      link_we    = (state_ff == S_LINK2) && out_free;
      link_raddr = 10'(drain_item_ff - 11'd1);
   end

   always_ff @(posedge clock) begin
      if (head_we) begin
         heads_mem[head_waddr] <= head_wdata;
      end
      head_q_ff <= heads_mem[head_raddr];
   end

   always_ff @(posedge clock) begin
      if (link_we) begin
         links_mem[pcnt_ff[9:0]] <= head_q_ff;
         rec_mem[pcnt_ff[9:0]]   <= {open_first_ff[11:0], open_total_ff};
      end
      link_q_ff <= links_mem[link_raddr];
      rec_q_ff  <= rec_mem[link_raddr];
   end

   // result beat selection
   always_comb begin
      emit      = 1'b0;
      emit_data = '0;
      unique case (state_ff)
         S_VFIN: begin
            if (item_ff.last_vertex && verdict != ST_ACCEPTED && out_free) begin
               emit                   = 1'b1;
               emit_data.status       = verdict;
               emit_data.first_vertex = first_w[11:0];
               emit_data.vertex_total = total_n[7:0];
            end
         end
         S_LINK2: begin
            if (out_free) begin
               emit                    = 1'b1;
               emit_data.status        = ST_ACCEPTED;
               emit_data.polygon_index = pcnt_ff[9:0];
               emit_data.first_vertex  = open_first_ff[11:0];
               emit_data.vertex_total  = open_total_ff[7:0];
               emit_data.bucket        = bk_ff;
            end
         end
         S_DRAIN: begin
            if (drain_done_ff && out_free) begin
               emit             = 1'b1;
               emit_data.status = ST_DRAIN_DONE;
            end
         end
         S_DOUT: begin
            if (out_free) begin
               emit                    = 1'b1;
               emit_data.status        = ST_DRAINED;
               emit_data.polygon_index = link_raddr;
               emit_data.first_vertex  = rec_q_ff[20:9];
               emit_data.vertex_total  = rec_q_ff[7:0];
               emit_data.bucket        = drain_bucket_ff;
            end
         end
         default: begin
            emit = 1'b0;
         end
      endcase
   end

   // hold or load the output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (emit) begin
         rsp_ff <= emit_data;
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         normal_x_ff      <= 16'sd0;
         normal_y_ff      <= 16'sd0;
         normal_z_ff      <= 16'sd16384;
         view_distance_ff <= 26'sd0;
         near_limit_ff    <= 20'd1024;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_NORMAL_X:      normal_x_ff      <= csr_wdata[15:0];
            CSR_NORMAL_Y:      normal_y_ff      <= csr_wdata[15:0];
            CSR_NORMAL_Z:      normal_z_ff      <= csr_wdata[15:0];
            CSR_VIEW_DISTANCE: view_distance_ff <= csr_wdata;
            CSR_NEAR_LIMIT:    near_limit_ff    <= csr_wdata[19:0];
            default: ;
         endcase
      end
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_CLR;
         clr_addr_ff     <= 12'd0;
         pcnt_ff         <= 11'd0;
         vcnt_ff         <= 13'd0;
         open_first_ff   <= 13'd0;
         open_total_ff   <= 9'd0;
         sum_ff          <= 36'sd0;
         peak_ff         <= {1'b1, 27'd0};
         drain_bucket_ff <= 12'(BUCKET_COUNT - 1);
         drain_item_ff   <= 11'd0;
         drain_done_ff   <= 1'b0;
         k_ff            <= 2'd0;
         div_cnt_ff      <= 6'd0;
      end else begin
         unique case (state_ff)
            S_CLR: begin
               clr_addr_ff <= clr_addr_ff + 12'd1;
               if (clr_addr_ff == 12'(BUCKET_COUNT - 1)) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (req_valid) begin
                  item_ff <= req_payload;
                  acc_ff  <= 42'sd0;
                  k_ff    <= 2'd0;
                  case (req_payload.operation)
                     OP_CLEAR: begin
                        pcnt_ff         <= 11'd0;
                        vcnt_ff         <= 13'd0;
                        open_first_ff   <= 13'd0;
                        open_total_ff   <= 9'd0;
                        sum_ff          <= 36'sd0;
                        peak_ff         <= {1'b1, 27'd0};
                        drain_bucket_ff <= 12'(BUCKET_COUNT - 1);
                        drain_item_ff   <= 11'd0;
                        drain_done_ff   <= 1'b0;
                        clr_addr_ff     <= 12'd0;
                        state_ff        <= S_CLR;
                     end
                     OP_VERTEX: state_ff <= S_VMUL;
                     OP_DRAIN:  state_ff <= S_DRAIN;
                     default:   state_ff <= S_IDLE;
                  endcase
               end
            end
            S_VMUL: begin
               product_ff <= mul_a * mul_b;
               if (k_ff != 2'd0) begin
                  acc_ff <= acc_ff + 42'(product_ff);
               end
               k_ff <= k_ff + 2'd1;
               if (k_ff == 2'd2) begin
                  state_ff <= S_VACC;
               end
            end
            S_VACC: begin
               acc_ff   <= acc_ff + 42'(product_ff);
               state_ff <= S_VFIN;
            end
            S_VFIN: begin
               if (!item_ff.last_vertex) begin
                  open_first_ff <= first_w;
                  sum_ff        <= sum_n;
                  peak_ff       <= peak_n;
                  open_total_ff <= total_n;
                  vcnt_ff       <= vcnt_n;
                  state_ff      <= S_IDLE;
               end else if (verdict != ST_ACCEPTED) begin
                  // drop: rewind the vertex store to the polygon start
                  if (out_free) begin
                     open_first_ff <= first_w;
                     vcnt_ff       <= first_w;
                     open_total_ff <= 9'd0;
                     sum_ff        <= 36'sd0;
                     peak_ff       <= {1'b1, 27'd0};
                     state_ff      <= S_IDLE;
                  end
               end else begin
                  open_first_ff <= first_w;
                  sum_ff        <= sum_n;
                  peak_ff       <= peak_n;
                  open_total_ff <= total_n;
                  vcnt_ff       <= vcnt_n;
                  neg_ff        <= sum_n[35];
                  div_q_ff      <= sum_n[35] ? ~sum_n[34:0] : sum_n[34:0];
                  div_rem_ff    <= 9'd0;
                  div_cnt_ff    <= 6'd0;
                  state_ff      <= S_DIV;
               end
            end
            S_DIV: begin
               div_rem_ff <= rem_n[8:0];
               div_q_ff   <= {div_q_ff[33:0], q_bit};
               div_cnt_ff <= div_cnt_ff + 6'd1;
               if (div_cnt_ff == 6'(DIV_STEPS - 1)) begin
                  state_ff <= S_BKT;
               end
            end
            S_BKT: begin
               bk_ff    <= bk_n;
               state_ff <= S_LINK;
            end
            S_LINK: begin
               state_ff <= S_LINK2;
            end
            S_LINK2: begin
               if (out_free) begin
                  pcnt_ff       <= pcnt_ff + 11'd1;
                  open_total_ff <= 9'd0;
                  sum_ff        <= 36'sd0;
                  peak_ff       <= {1'b1, 27'd0};
                  state_ff      <= S_IDLE;
               end
            end
            S_DRAIN: begin
               priority if (drain_done_ff) begin
                  if (out_free) begin
                     state_ff <= S_IDLE;
                  end
               end else if (drain_item_ff == 11'd0) begin
                  state_ff <= S_DHEAD;
               end else begin
                  state_ff <= S_DOUT;
               end
            end
            S_DHEAD: begin
               // empty bucket: step down, else start its chain
               if (head_q_ff == 11'd0) begin
                  if (drain_bucket_ff == 12'd0) begin
                     drain_done_ff <= 1'b1;
                  end else begin
                     drain_bucket_ff <= drain_bucket_ff - 12'd1;
                  end
               end else begin
                  drain_item_ff <= head_q_ff;
               end
               state_ff <= S_DRAIN;
            end
            S_DOUT: begin
               if (out_free) begin
                  if (link_q_ff == 11'd0) begin
                     drain_item_ff <= 11'd0;
                     if (drain_bucket_ff == 12'd0) begin
                        drain_done_ff <= 1'b1;
                     end else begin
                        drain_bucket_ff <= drain_bucket_ff - 12'd1;
                     end
                  end else begin
                     drain_item_ff <= link_q_ff;
                  end
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   // checks
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      emit |-> (!rsp_valid_ff || !rsp_stall))
      else $error("result beat overwrote a waiting beat");

   a_pcnt_bound: assert property (@(posedge clock) disable iff (reset)
      pcnt_ff <= 11'(MAX_POLYGONS))
      else $error("polygon count beyond store size");

   a_link_room: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_LINK2) |-> (pcnt_ff < 11'(MAX_POLYGONS)))
      else $error("linking into a full polygon store");

   a_div_exit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) |=> (state_ff == S_DIV || state_ff == S_BKT))
      else $error("divider left early");

endmodule
